// ===== sv/rarmt_pkg.sv =====
package rarmt_pkg;

  localparam int MAX_POSITIONS = 1024;
  localparam int POS_W         = 11;
  localparam int ADDR_W        = 11;
  localparam int NODE_COUNT    = 2048;
  localparam int VAL_W         = 48;
  localparam int DELTA_W       = 16;
  localparam int STACK_DEPTH   = 16;
  localparam int SP_W          = 4;

  // -1000000000 at 48 bits
  localparam logic [VAL_W-1:0] EMPTY_SENTINEL = 48'hFFFF_C465_3600;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // phase stored with a pushed frame: which child was entered
  localparam logic PH_LEFT  = 1'b0;
  localparam logic PH_RIGHT = 1'b1;

  typedef enum logic [1:0] {MODE_ADD, MODE_QUERY, MODE_BUILD} mode_e;
  typedef enum logic [1:0] {RD_NONE, RD_K, RD_A, RD_B} rd_e;
  typedef enum logic [2:0] {
    WR_NONE, WR_BUILD, WR_APPLY, WR_CLRPEND, WR_CHILD, WR_COMBINE
  } wr_e;
  typedef enum logic [1:0] {GO_NONE, GO_LEFT, GO_RIGHT} go_e;

  typedef struct packed {
    logic                      op;
    logic [POS_W-1:0]          range_low;
    logic [POS_W-1:0]          range_high;
    logic signed [DELTA_W-1:0] delta;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] max_value;
    logic [POS_W-1:0]        max_position;
    logic                    range_ok;
  } out_t;

  typedef struct packed {
    logic [VAL_W-1:0] max_val;
    logic [POS_W-1:0] max_pos;
    logic [VAL_W-1:0] pend;
  } node_t;

  typedef struct packed {
    logic [ADDR_W-1:0] k;
    logic [POS_W-1:0]  l;
    logic [POS_W-1:0]  r;
    logic              phase;
  } frame_t;

  typedef struct packed {
    logic  load_item;
    logic  start_build;
    logic  start_walk;
    rd_e   rd_sel;
    wr_e   wr_sel;
    logic  acc_en;
    logic  latch_pend;
    logic  latch_a;
    logic  push;
    logic  push_phase;
    go_e   go_sel;
    logic  pop;
    logic  load_out;
  } cmd_t;

  typedef struct packed {
    logic  cfg_wr;
    mode_e mode;
    logic  ok;
    logic  covered;
    logic  leaf;
    logic  want_left;
    logic  want_right;
    logic  pend_nz;
    logic  stack_empty;
    logic  stack_full;
    logic  phase;
    logic  out_busy;
  } sts_t;

endpackage

// ===== sv/range_add_range_max_tree.sv =====
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_ready_o  | in_data_i (op, range_low, range_high, delta)
// out     | output    | out_valid_o / out_ready_i| out_data_o (max_value, max_position, range_ok)
// cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_data_i (active_size)
//
// One transaction at a time: a tree walk on one read port, with more steps per split node
// than per covered node, visiting up to about four nodes per level over eleven levels;
// a bad range goes straight to the result.
// After reset and each active_size write, a rebuild walk clears the tree, visiting about
// 2 * active_size nodes.
// A finished result waits in the output register while the next transaction is accepted;
// the walk stalls only when a new result meets a full register.
module range_add_range_max_tree (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rarmt_pkg::in_t              in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rarmt_pkg::out_t             out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rarmt_pkg::POS_W-1:0] cfg_data_i
);

  rarmt_pkg::cmd_t cmd;
  rarmt_pkg::sts_t sts;

  // configuration is always taken; it restarts the rebuild
  assign cfg_ready_o = 1'b1;

  rarmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rarmt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

`ifndef ASSERT_OFF
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction accepted during a walk");

  a_cfg_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> !in_ready_o)
    else $error("input accepted right after a size write");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !sts.out_busy)
    else $error("result register overwritten while held");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !sts.stack_full)
    else $error("walk stack overflow");
`endif

endmodule

// ===== sv/rarmt_ctrl.sv =====
module rarmt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rarmt_pkg::sts_t sts_i,
  output rarmt_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_BOOT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_ENTER = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_PDA   = 4'd5;
  localparam logic [3:0] S_PDB   = 4'd6;
  localparam logic [3:0] S_DESC  = 4'd7;
  localparam logic [3:0] S_RET   = 4'd8;
  localparam logic [3:0] S_POST  = 4'd9;
  localparam logic [3:0] S_CMA   = 4'd10;
  localparam logic [3:0] S_CMB   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0] state_q, state_d;

  // accept only when idle and no configuration write competes
  assign in_ready_o = (state_q == S_IDLE) && !sts_i.cfg_wr;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = rarmt_pkg::RD_NONE;
    cmd_o.wr_sel = rarmt_pkg::WR_NONE;
    cmd_o.go_sel = rarmt_pkg::GO_NONE;
    case (state_q)
      S_BOOT: begin
        cmd_o.start_build = 1'b1;
        state_d = S_ENTER;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.ok) begin
          cmd_o.start_walk = 1'b1;
          state_d = S_ENTER;
        end else begin
          state_d = S_FIN;
        end
      end
      S_ENTER: begin
        if (sts_i.mode == rarmt_pkg::MODE_BUILD) begin
          cmd_o.wr_sel = rarmt_pkg::WR_BUILD;
          if (sts_i.leaf) begin
            state_d = S_RET;
          end else begin
            cmd_o.push = 1'b1;
            cmd_o.push_phase = rarmt_pkg::PH_LEFT;
            cmd_o.go_sel = rarmt_pkg::GO_LEFT;
          end
        end else begin
          cmd_o.rd_sel = rarmt_pkg::RD_K;
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (sts_i.covered) begin
          if (sts_i.mode == rarmt_pkg::MODE_ADD) begin
            cmd_o.wr_sel = rarmt_pkg::WR_APPLY;
          end else begin
            cmd_o.acc_en = 1'b1;
          end
          state_d = S_RET;
        end else begin
          cmd_o.latch_pend = 1'b1;
          if (sts_i.pend_nz) begin
            cmd_o.wr_sel = rarmt_pkg::WR_CLRPEND;
            cmd_o.rd_sel = rarmt_pkg::RD_A;
            state_d = S_PDA;
          end else begin
            state_d = S_DESC;
          end
        end
      end
      S_PDA: begin
        cmd_o.wr_sel = rarmt_pkg::WR_CHILD;
        cmd_o.rd_sel = rarmt_pkg::RD_B;
        state_d = S_PDB;
      end
      S_PDB: begin
        cmd_o.wr_sel = rarmt_pkg::WR_CHILD;
        state_d = S_DESC;
      end
      S_DESC: begin
        cmd_o.push = 1'b1;
        if (sts_i.want_left) begin
          cmd_o.push_phase = rarmt_pkg::PH_LEFT;
          cmd_o.go_sel = rarmt_pkg::GO_LEFT;
        end else begin
          cmd_o.push_phase = rarmt_pkg::PH_RIGHT;
          cmd_o.go_sel = rarmt_pkg::GO_RIGHT;
        end
        state_d = S_ENTER;
      end
      S_RET: begin
        if (sts_i.stack_empty) begin
          state_d = (sts_i.mode == rarmt_pkg::MODE_BUILD) ? S_IDLE : S_FIN;
        end else begin
          cmd_o.pop = 1'b1;
          state_d = S_POST;
        end
      end
      S_POST: begin
        if (sts_i.phase == rarmt_pkg::PH_LEFT &&
            (sts_i.mode == rarmt_pkg::MODE_BUILD || sts_i.want_right)) begin
          cmd_o.push = 1'b1;
          cmd_o.push_phase = rarmt_pkg::PH_RIGHT;
          cmd_o.go_sel = rarmt_pkg::GO_RIGHT;
          state_d = S_ENTER;
        end else if (sts_i.mode == rarmt_pkg::MODE_ADD) begin
          cmd_o.rd_sel = rarmt_pkg::RD_A;
          state_d = S_CMA;
        end else begin
          state_d = S_RET;
        end
      end
      S_CMA: begin
        cmd_o.latch_a = 1'b1;
        cmd_o.rd_sel = rarmt_pkg::RD_B;
        state_d = S_CMB;
      end
      S_CMB: begin
        cmd_o.wr_sel = rarmt_pkg::WR_COMBINE;
        state_d = S_RET;
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_BOOT;
    endcase
    // a configuration write restarts the rebuild
    if (sts_i.cfg_wr) begin
      cmd_o = '0;
      cmd_o.rd_sel = rarmt_pkg::RD_NONE;
      cmd_o.wr_sel = rarmt_pkg::WR_NONE;
      cmd_o.go_sel = rarmt_pkg::GO_NONE;
      cmd_o.start_build = 1'b1;
      state_d = S_ENTER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BOOT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/rarmt_dp.sv =====
module rarmt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rarmt_pkg::in_t                in_data_i,
  input  logic                          cfg_valid_i,
  input  logic [rarmt_pkg::POS_W-1:0]   cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rarmt_pkg::out_t               out_data_o,
  input  rarmt_pkg::cmd_t               cmd_i,
  output rarmt_pkg::sts_t               sts_o
);

  localparam logic [rarmt_pkg::POS_W-1:0] MAX_SIZE =
    rarmt_pkg::POS_W'(rarmt_pkg::MAX_POSITIONS);

  rarmt_pkg::node_t mem_q [rarmt_pkg::NODE_COUNT];
  rarmt_pkg::node_t rdata_q;
  rarmt_pkg::node_t wdata;
  rarmt_pkg::node_t a_q;
  logic [rarmt_pkg::ADDR_W-1:0] raddr;
  logic [rarmt_pkg::ADDR_W-1:0] raddr_q;
  logic [rarmt_pkg::ADDR_W-1:0] waddr;
  logic                         re;
  logic                         we;

  rarmt_pkg::frame_t stack_q [rarmt_pkg::STACK_DEPTH];
  rarmt_pkg::frame_t cur_q;
  rarmt_pkg::frame_t push_frame;
  logic [rarmt_pkg::SP_W-1:0] sp_q;
  logic [rarmt_pkg::SP_W-1:0] sp_top;

  rarmt_pkg::in_t   item_q;
  rarmt_pkg::mode_e mode_q;
  logic [rarmt_pkg::POS_W-1:0] size_q;
  logic [rarmt_pkg::POS_W-1:0] cfg_size;
  logic [rarmt_pkg::VAL_W-1:0] pend_q;
  logic [rarmt_pkg::VAL_W-1:0] delta_ext;
  logic [rarmt_pkg::VAL_W-1:0] acc_max_q;
  logic [rarmt_pkg::POS_W-1:0] acc_pos_q;
  logic                        acc_valid_q;
  logic                        acc_take;
  logic                        out_valid_q;
  rarmt_pkg::out_t             out_q;
  rarmt_pkg::out_t             out_d;

  logic [rarmt_pkg::POS_W:0]   mid_sum;
  logic [rarmt_pkg::POS_W-1:0] mid;
  logic [rarmt_pkg::ADDR_W-1:0] child_a;
  logic [rarmt_pkg::ADDR_W-1:0] child_b;
  logic                        ok;

  // split the span at the floor of its midpoint
  assign mid_sum = {1'b0, cur_q.l} + {1'b0, cur_q.r};
  assign mid     = mid_sum[rarmt_pkg::POS_W:1];
  assign child_a = {cur_q.k[rarmt_pkg::ADDR_W-2:0], 1'b0};
  assign child_b = {cur_q.k[rarmt_pkg::ADDR_W-2:0], 1'b1};
  assign sp_top  = sp_q - rarmt_pkg::SP_W'(1);

  assign delta_ext = {{(rarmt_pkg::VAL_W - rarmt_pkg::DELTA_W){item_q.delta[rarmt_pkg::DELTA_W-1]}},
                      item_q.delta};

  assign ok = (item_q.range_low != '0) && (item_q.range_low <= item_q.range_high) &&
              (item_q.range_high <= size_q);

  // saturate the written size into the legal range
  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_size = rarmt_pkg::POS_W'(1);
    end else if (cfg_data_i > MAX_SIZE) begin
      cfg_size = MAX_SIZE;
    end else begin
      cfg_size = cfg_data_i;
    end
  end

  // status toward the controller
  always_comb begin
    sts_o.cfg_wr      = cfg_valid_i;
    sts_o.mode        = mode_q;
    sts_o.ok          = ok;
    sts_o.covered     = (item_q.range_low <= cur_q.l) && (cur_q.r <= item_q.range_high);
    sts_o.leaf        = (cur_q.l == cur_q.r);
    sts_o.want_left   = (item_q.range_low <= mid);
    sts_o.want_right  = (item_q.range_high > mid);
    sts_o.pend_nz     = (rdata_q.pend != '0);
    sts_o.stack_empty = (sp_q == '0);
    sts_o.stack_full  = (sp_q == rarmt_pkg::SP_W'(rarmt_pkg::STACK_DEPTH - 1));
    sts_o.phase       = cur_q.phase;
    sts_o.out_busy    = out_valid_q && !out_ready_i;
  end

  // read address select
  always_comb begin
    re    = 1'b1;
    raddr = cur_q.k;
    case (cmd_i.rd_sel)
      rarmt_pkg::RD_K: raddr = cur_q.k;
      rarmt_pkg::RD_A: raddr = child_a;
      rarmt_pkg::RD_B: raddr = child_b;
      default:         re = 1'b0;
    endcase
  end

  // node write data
  always_comb begin
    we    = 1'b1;
    waddr = cur_q.k;
    wdata = rdata_q;
    case (cmd_i.wr_sel)
      rarmt_pkg::WR_BUILD: begin
        wdata.max_val = '0;
        wdata.max_pos = cur_q.l;
        wdata.pend    = '0;
      end
      rarmt_pkg::WR_APPLY: begin
        wdata.max_val = rdata_q.max_val + delta_ext;
        wdata.pend    = rdata_q.pend + delta_ext;
      end
      rarmt_pkg::WR_CLRPEND: begin
        wdata.pend = '0;
      end
      rarmt_pkg::WR_CHILD: begin
        waddr = raddr_q;
        wdata.max_val = rdata_q.max_val + pend_q;
        wdata.pend    = rdata_q.pend + pend_q;
      end
      rarmt_pkg::WR_COMBINE: begin
        if ($signed(a_q.max_val) >= $signed(rdata_q.max_val)) begin
          wdata.max_val = a_q.max_val;
          wdata.max_pos = a_q.max_pos;
        end else begin
          wdata.max_val = rdata_q.max_val;
          wdata.max_pos = rdata_q.max_pos;
        end
        wdata.pend = '0;
      end
      default: we = 1'b0;
    endcase
  end

  // node memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // the left piece wins a tie
  assign acc_take = !acc_valid_q || !($signed(acc_max_q) >= $signed(rdata_q.max_val));

  // frame pushed on descent, tagged with the child being entered
  always_comb begin
    push_frame       = cur_q;
    push_frame.phase = cmd_i.push_phase;
  end

  // result word
  always_comb begin
    out_d = '0;
    out_d.range_ok = ok;
    if (item_q.op == rarmt_pkg::OP_QUERY) begin
      if (ok) begin
        out_d.max_value    = acc_max_q;
        out_d.max_position = acc_pos_q;
      end else begin
        out_d.max_value = rarmt_pkg::EMPTY_SENTINEL;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (re) begin
      raddr_q <= raddr;
    end
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.latch_pend) begin
      pend_q <= rdata_q.pend;
    end
    if (cmd_i.latch_a) begin
      a_q <= rdata_q;
    end
    if (cmd_i.acc_en && acc_take) begin
      acc_max_q <= rdata_q.max_val;
      acc_pos_q <= rdata_q.max_pos;
    end
    if (cmd_i.push) begin
      stack_q[sp_q] <= push_frame;
    end
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  // control registers: walk position, stack pointer, mode, size, accumulator valid, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      sp_q        <= '0;
      mode_q      <= rarmt_pkg::MODE_BUILD;
      size_q      <= MAX_SIZE;
      acc_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_item) begin
        mode_q <= (in_data_i.op == rarmt_pkg::OP_QUERY) ? rarmt_pkg::MODE_QUERY
                                                        : rarmt_pkg::MODE_ADD;
      end
      if (cmd_i.start_build) begin
        mode_q  <= rarmt_pkg::MODE_BUILD;
        sp_q    <= '0;
        cur_q.k <= rarmt_pkg::ADDR_W'(1);
        cur_q.l <= rarmt_pkg::POS_W'(1);
        cur_q.r <= cfg_valid_i ? cfg_size : size_q;
        if (cfg_valid_i) begin
          size_q <= cfg_size;
        end
      end else if (cmd_i.start_walk) begin
        sp_q        <= '0;
        acc_valid_q <= 1'b0;
        cur_q.k     <= rarmt_pkg::ADDR_W'(1);
        cur_q.l     <= rarmt_pkg::POS_W'(1);
        cur_q.r     <= size_q;
      end else begin
        if (cmd_i.acc_en) begin
          acc_valid_q <= 1'b1;
        end
        if (cmd_i.pop) begin
          cur_q <= stack_q[sp_top];
          sp_q  <= sp_top;
        end else if (cmd_i.push) begin
          sp_q <= sp_q + rarmt_pkg::SP_W'(1);
        end
        case (cmd_i.go_sel)
          rarmt_pkg::GO_LEFT: begin
            cur_q.k <= child_a;
            cur_q.r <= mid;
          end
          rarmt_pkg::GO_RIGHT: begin
            cur_q.k <= child_b;
            cur_q.l <= mid + rarmt_pkg::POS_W'(1);
          end
          default: ;
        endcase
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/range_add_range_max_tree_tb.sv =====
`timescale 1ns / 1ps

// Holds the expected contents of the position array and the pending results.
class range_max_scoreboard;
  logic signed [rarmt_pkg::VAL_W-1:0] pos_value[1:rarmt_pkg::MAX_POSITIONS];
  int unsigned                        size;
  rarmt_pkg::out_t                    expected_q[$];
  int                                 mismatches;

  function new();
    mismatches = 0;
    set_size(rarmt_pkg::MAX_POSITIONS);
  endfunction

  // Saturate into 1..MAX_POSITIONS and clear every position.
  function void set_size(int unsigned v);
    if (v < 1) v = 1;
    if (v > rarmt_pkg::MAX_POSITIONS) v = rarmt_pkg::MAX_POSITIONS;
    size = v;
    for (int i = 1; i <= rarmt_pkg::MAX_POSITIONS; i++) pos_value[i] = '0;
  endfunction

  // Apply an accepted transaction and queue its result.
  function void note_input(rarmt_pkg::in_t t);
    rarmt_pkg::out_t                    res;
    logic signed [rarmt_pkg::VAL_W-1:0] best;
    int unsigned                        lo, hi;
    lo = t.range_low;
    hi = t.range_high;
    res = '0;
    res.range_ok = (lo >= 1) && (lo <= hi) && (hi <= size);
    if (t.op == rarmt_pkg::OP_ADD) begin
      if (res.range_ok) begin
        for (int i = lo; i <= hi; i++) pos_value[i] = pos_value[i] + 48'(t.delta);
      end
    end else if (res.range_ok) begin
      // leftmost wins on a tie
      best = pos_value[lo];
      res.max_position = rarmt_pkg::POS_W'(lo);
      for (int i = lo + 1; i <= hi; i++) begin
        if (pos_value[i] > best) begin
          best = pos_value[i];
          res.max_position = rarmt_pkg::POS_W'(i);
        end
      end
      res.max_value = best;
    end else begin
      res.max_value = rarmt_pkg::EMPTY_SENTINEL;
    end
    expected_q.push_back(res);
  endfunction

  function void check_result(rarmt_pkg::out_t got);
    rarmt_pkg::out_t exp_r;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: value %0d pos %0d ok %0b",
                                     got.max_value, got.max_position, got.range_ok);
      return;
    end
    exp_r = expected_q.pop_front();
    if (got.max_value !== exp_r.max_value || got.max_position !== exp_r.max_position ||
        got.range_ok !== exp_r.range_ok) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected value %0d pos %0d ok %0b, got value %0d pos %0d ok %0b",
                 exp_r.max_value, exp_r.max_position, exp_r.range_ok,
                 got.max_value, got.max_position, got.range_ok);
    end
  endfunction
endclass

module range_add_range_max_tree_tb;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  rarmt_pkg::in_t                in_data_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  rarmt_pkg::out_t               out_data_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [rarmt_pkg::POS_W-1:0]   cfg_data_i;

  range_max_scoreboard sb;
  logic                quiet;

  range_add_range_max_tree uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Send one transaction, with an occasional idle burst in front of it.
  task automatic send_item(logic op, int unsigned lo, int unsigned hi, int d);
    rarmt_pkg::in_t t;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    t.op         = op;
    t.range_low  = lo[rarmt_pkg::POS_W-1:0];
    t.range_high = hi[rarmt_pkg::POS_W-1:0];
    t.delta      = d[rarmt_pkg::DELTA_W-1:0];
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(t);
  endtask

  // Drop valid and wait for every pending result.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_size(int unsigned v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v[rarmt_pkg::POS_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_size(v);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed ranges; some noise over the full field width.
  task automatic random_items(int n);
    int unsigned lo, hi, s;
    int          d;
    for (int i = 0; i < n; i++) begin
      s = sb.size;
      if ($urandom_range(0, 99) < 15) begin
        lo = $urandom_range(0, 2047);
        hi = $urandom_range(0, 2047);
      end else begin
        lo = $urandom_range(1, s);
        if ($urandom_range(0, 1)) hi = $urandom_range(lo, s);
        else hi = (lo + $urandom_range(0, 8) > s) ? s : lo + $urandom_range(0, 8);
      end
      if ($urandom_range(0, 2) == 0) d = $urandom_range(0, 4) - 2;
      else d = $urandom_range(0, 65535);
      send_item(logic'($urandom_range(0, 1)), lo, hi, d);
    end
  endtask

  // Stall the result side in random bursts.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      if (!quiet) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
    end
  end

  // Check each accepted result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    sb          = new();
    quiet       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, bad ranges, ties.
    send_item(rarmt_pkg::OP_QUERY, 1, 1024, 0);
    send_item(rarmt_pkg::OP_QUERY, 512, 512, 0);
    send_item(rarmt_pkg::OP_ADD, 1, 1024, 32767);
    send_item(rarmt_pkg::OP_ADD, 1024, 1024, -32768);
    send_item(rarmt_pkg::OP_ADD, 2, 1023, 32767);
    send_item(rarmt_pkg::OP_QUERY, 1, 1024, 0);
    send_item(rarmt_pkg::OP_QUERY, 1024, 1024, 0);
    send_item(rarmt_pkg::OP_QUERY, 0, 5, 0);
    send_item(rarmt_pkg::OP_QUERY, 5, 4, 0);
    send_item(rarmt_pkg::OP_QUERY, 3, 1025, 0);
    send_item(rarmt_pkg::OP_QUERY, 2047, 2047, 0);
    send_item(rarmt_pkg::OP_ADD, 0, 2047, 100);
    send_item(rarmt_pkg::OP_ADD, 9, 8, -5);
    send_item(rarmt_pkg::OP_ADD, 30, 30, 5);
    send_item(rarmt_pkg::OP_ADD, 34, 34, 5);
    send_item(rarmt_pkg::OP_QUERY, 25, 40, 0);
    send_item(rarmt_pkg::OP_QUERY, 31, 33, 0);
    send_item(rarmt_pkg::OP_ADD, 1, 1, -32768);
    send_item(rarmt_pkg::OP_QUERY, 1, 1, 0);

    random_items(400);
    write_size(1);
    random_items(100);
    write_size(0);
    random_items(60);
    write_size(2047);
    random_items(300);
    write_size(5);
    random_items(200);
    write_size(64);
    random_items(300);
    write_size(1000);
    quiet = 1'b1;
    random_items(400);

    drain();
    repeat (400) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
